@@ design/epte_pkg.sv @@
// Shared constants, codes and types for the envelope point table editor.
`default_nettype none

package epte_pkg;

   // Default sizes of the table and its payload words
   localparam int DEF_MAX_POINTS = 32;
   localparam int DEF_TIME_BITS  = 16;
   localparam int DEF_VALUE_BITS = 16;

   // Fixed field widths
   localparam int KIND_BITS   = 3;
   localparam int SEL_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int NUM_MARKS   = 4;

   // Command kinds
   localparam logic [KIND_BITS-1:0] KIND_SET    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_MARK   = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 3'd5;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // Marker slots
   localparam logic [SEL_BITS-1:0] MS_SUS_BEGIN  = 2'd0;
   localparam logic [SEL_BITS-1:0] MS_SUS_END    = 2'd1;
   localparam logic [SEL_BITS-1:0] MS_LOOP_START = 2'd2;
   localparam logic [SEL_BITS-1:0] MS_LOOP_END   = 2'd3;

   // Marker update operations
   typedef enum logic [2:0] {
      MK_HOLD  = 3'd0,
      MK_CLEAR = 3'd1,
      MK_WRITE = 3'd2,
      MK_UP    = 3'd3,
      MK_DOWN  = 3'd4,
      MK_DROP  = 3'd5
   } mark_op_type;

   typedef struct packed {
      mark_op_type          op;
      logic [SEL_BITS-1:0]  sel;
   } mark_ctl_type;

endpackage

`default_nettype wire

@@ design/epte_if.sv @@
// Request and response channel interfaces of the envelope point table editor.
`default_nettype none

interface epte_req_if #(
   parameter int IDX_BITS   = 6,
   parameter int TIME_BITS  = 16,
   parameter int VALUE_BITS = 16
);
   import epte_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind;
   logic [IDX_BITS-1:0]    index;
   logic [TIME_BITS-1:0]   point_time;
   logic [VALUE_BITS-1:0]  point_value;
   logic [SEL_BITS-1:0]    marker_sel;

   modport source (
      output valid, kind, index, point_time, point_value, marker_sel,
      input  ready
   );
   modport sink (
      input  valid, kind, index, point_time, point_value, marker_sel,
      output ready
   );
endinterface

interface epte_rsp_if #(
   parameter int IDX_BITS   = 6,
   parameter int POS_BITS   = 5,
   parameter int TIME_BITS  = 16,
   parameter int VALUE_BITS = 16
);
   import epte_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [POS_BITS-1:0]    result_index;
   logic [TIME_BITS-1:0]   read_time;
   logic [VALUE_BITS-1:0]  read_value;
   logic [IDX_BITS-1:0]    point_count;
   logic [IDX_BITS-1:0]    sus_begin_out;
   logic [IDX_BITS-1:0]    sus_end_out;
   logic [IDX_BITS-1:0]    loop_begin_out;
   logic [IDX_BITS-1:0]    loop_end_out;

   modport source (
      output valid, status, result_index, read_time, read_value, point_count,
             sus_begin_out, sus_end_out, loop_begin_out, loop_end_out,
      input  ready
   );
   modport sink (
      input  valid, status, result_index, read_time, read_value, point_count,
             sus_begin_out, sus_end_out, loop_begin_out, loop_end_out,
      output ready
   );
endinterface

`default_nettype wire

@@ design/epte_mem.sv @@
// Point memory: one write port, one read port, registered read data.
`default_nettype none

module epte_mem #(
   parameter int DEPTH      = 32,
   parameter int WIDTH      = 32,
   parameter int ADDR_BITS  = 5
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_BITS-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_BITS-1:0]  rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/epte_marks.sv @@
// Marker register file: sustain and loop markers with shift, drop, write and clear.
`default_nettype none

module epte_marks #(
   parameter int MAX_POINTS = 32,
   parameter int IDX_BITS   = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire epte_pkg::mark_ctl_type      ctl,
   input  wire logic [IDX_BITS-1:0]         lo,
   input  wire logic [IDX_BITS-1:0]         hi,
   output logic [epte_pkg::NUM_MARKS-1:0][IDX_BITS-1:0] marks_out
);
   import epte_pkg::*;

   localparam logic [IDX_BITS-1:0] NONE_MARK = IDX_BITS'(MAX_POINTS);

   logic [NUM_MARKS-1:0][IDX_BITS-1:0] marks_ff;
   logic [NUM_MARKS-1:0][IDX_BITS-1:0] marks_in;

   // Work out each marker's next value
   always_comb begin
      logic [IDX_BITS-1:0] cur;
      logic [SEL_BITS-1:0] slot;
      logic [SEL_BITS-1:0] base;
      logic                hit;
      marks_in = marks_ff;
      for (int j = 0; j < NUM_MARKS; j++) begin
         slot = SEL_BITS'(j);
         cur  = marks_ff[slot];
         base = (slot >= MS_LOOP_START) ? MS_LOOP_START : MS_SUS_BEGIN;
         hit  = (marks_ff[base] == lo) || (marks_ff[base + 2'd1] == lo);
         case (ctl.op)
            MK_HOLD: begin
               marks_in[slot] = cur;
            end
            MK_CLEAR: begin
               marks_in[slot] = NONE_MARK;
            end
            MK_WRITE: begin
               if (ctl.sel == slot) marks_in[slot] = lo;
            end
            MK_UP: begin
               if (cur != NONE_MARK && cur >= lo && cur < hi) marks_in[slot] = cur + 1'b1;
            end
            MK_DOWN: begin
               if (cur != NONE_MARK && cur > lo && cur <= hi) marks_in[slot] = cur - 1'b1;
            end
            MK_DROP: begin
               // a pair that loses an endpoint goes to none as a whole
               if (hit) marks_in[slot] = NONE_MARK;
               else if (cur != NONE_MARK && cur > lo) marks_in[slot] = cur - 1'b1;
            end
            default: begin
               marks_in[slot] = cur;
            end
         endcase
      end
   end

   // Hold the markers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_MARKS; j++) marks_ff[SEL_BITS'(j)] <= NONE_MARK;
      end else begin
         marks_ff <= marks_in;
      end
   end

   assign marks_out = marks_ff;

endmodule

`default_nettype wire

@@ design/envelope_point_table_editor_core.sv @@
// Top level: command sequencer over the point memory and the marker file.
//
// Use: commands arrive on req_chan (valid/ready); one response per command
// leaves on rsp_chan with the status, new point index, read data, point count
// and all four markers after the command.
// req_chan.ready is high only while the sequencer is idle; one command is
// worked at a time, and the next one may be taken while the previous
// response still waits in the output register.
// After acceptance, marker write, clear, unused kinds and errors go from the
// decode state to the response; a read passes through a fetch state, and an
// insert into an empty table goes straight to placing. A set first checks both
// neighbours; insert, delete and a set that moves its point then walk the
// shift, which moves one entry per cycle through the single read port of the
// memory. The next command may be taken in the cycle after the response loads.
// Reset empties the table (count zero) and sets all markers to none; the
// point memory is not cleared, since no entry at or above the count is read.
// While the receiver stalls, a finished response holds in the output
// register and the sequencer waits before loading the next one.
`default_nettype none

module envelope_point_table_editor_core #(
   parameter int MAX_POINTS = epte_pkg::DEF_MAX_POINTS,
   parameter int TIME_BITS  = epte_pkg::DEF_TIME_BITS,
   parameter int VALUE_BITS = epte_pkg::DEF_VALUE_BITS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   epte_req_if.sink    req_chan,
   epte_rsp_if.source  rsp_chan
);
   import epte_pkg::*;

   localparam int IDX_BITS   = $clog2(MAX_POINTS + 1);
   localparam int POS_BITS   = $clog2(MAX_POINTS);
   localparam int ENTRY_BITS = TIME_BITS + VALUE_BITS;
   localparam logic [IDX_BITS-1:0] NONE_MARK = IDX_BITS'(MAX_POINTS);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_DECODE  = 8'b0000_0010,
      S_NEIGH_A = 8'b0000_0100,
      S_NEIGH_B = 8'b0000_1000,
      S_SCAN    = 8'b0001_0000,
      S_PLACE   = 8'b0010_0000,
      S_FETCH   = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [KIND_BITS-1:0]   kind_ff, kind_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [SEL_BITS-1:0]    sel_ff, sel_in;
   logic [IDX_BITS-1:0]    count_ff, count_in;
   logic [IDX_BITS-1:0]    ptr_ff, ptr_in;
   logic [IDX_BITS-1:0]    place_ff, place_in;
   logic                   up_ff, up_in;
   logic                   prev_lt_ff, prev_lt_in;

   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;
   logic [POS_BITS-1:0]    res_index_ff, res_index_in;
   logic [TIME_BITS-1:0]   res_time_ff, res_time_in;
   logic [VALUE_BITS-1:0]  res_value_ff, res_value_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic [TIME_BITS-1:0]   rsp_time_ff, rsp_time_in;
   logic [VALUE_BITS-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic [NUM_MARKS-1:0][IDX_BITS-1:0] rsp_marks_ff, rsp_marks_in;

   logic                   wr_en;
   logic [POS_BITS-1:0]    wr_addr;
   logic [ENTRY_BITS-1:0]  wr_data;
   logic [POS_BITS-1:0]    rd_addr;
   logic [ENTRY_BITS-1:0]  rd_data;
   logic [TIME_BITS-1:0]   rd_time;

   mark_ctl_type           mark_ctl;
   logic [IDX_BITS-1:0]    mark_lo;
   logic [IDX_BITS-1:0]    mark_hi;
   logic [NUM_MARKS-1:0][IDX_BITS-1:0] marks;

   logic [IDX_BITS-1:0]    last_idx;
   logic [IDX_BITS-1:0]    idx_plus;
   logic [IDX_BITS-1:0]    idx_minus;
   logic [IDX_BITS-1:0]    ptr_plus;
   logic [IDX_BITS-1:0]    ptr_minus;
   logic                   idx_ok;
   logic                   ptr_live;
   logic                   next_gt;
   logic                   down_go;

   epte_mem #(
      .DEPTH     (MAX_POINTS),
      .WIDTH     (ENTRY_BITS),
      .ADDR_BITS (POS_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   epte_marks #(
      .MAX_POINTS (MAX_POINTS),
      .IDX_BITS   (IDX_BITS)
   ) u_marks (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mark_ctl),
      .lo        (mark_lo),
      .hi        (mark_hi),
      .marks_out (marks)
   );

   // Decode helpers
   assign rd_time   = rd_data[ENTRY_BITS-1:VALUE_BITS];
   assign last_idx  = count_ff - 1'b1;
   assign idx_plus  = idx_ff + 1'b1;
   assign idx_minus = idx_ff - 1'b1;
   assign ptr_plus  = ptr_ff + 1'b1;
   assign ptr_minus = ptr_ff - 1'b1;
   assign idx_ok    = idx_ff < count_ff;
   assign ptr_live  = ptr_ff < count_ff;
   assign next_gt   = (idx_ff != last_idx) && (time_ff > rd_time);
   assign down_go   = ptr_live && ((kind_ff == KIND_DELETE) || (rd_time <= time_ff));

   // Sequence the command
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      value_in      = value_ff;
      sel_in        = sel_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      place_in      = place_ff;
      up_in         = up_ff;
      prev_lt_in    = prev_lt_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_time_in   = res_time_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_marks_in  = rsp_marks_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      rd_addr       = '0;
      mark_ctl.op   = MK_HOLD;
      mark_ctl.sel  = sel_ff;
      mark_lo       = idx_ff;
      mark_hi       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            // take the transaction and clear the result
            if (req_chan.valid) begin
               kind_in       = req_chan.kind;
               idx_in        = req_chan.index;
               time_in       = req_chan.point_time;
               value_in      = req_chan.point_value;
               sel_in        = req_chan.marker_sel;
               res_status_in = ST_OK;
               res_index_in  = '0;
               res_time_in   = '0;
               res_value_in  = '0;
               state_in      = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_DONE;
            case (kind_ff)
               KIND_SET: begin
                  if (idx_ok) begin
                     rd_addr  = idx_minus[POS_BITS-1:0];
                     state_in = S_NEIGH_A;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               KIND_INSERT: begin
                  if (count_ff == NONE_MARK) begin
                     res_status_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     place_in = '0;
                     up_in    = 1'b1;
                     state_in = S_PLACE;
                  end else begin
                     rd_addr  = last_idx[POS_BITS-1:0];
                     ptr_in   = last_idx;
                     up_in    = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               KIND_DELETE: begin
                  if (idx_ok) begin
                     rd_addr  = idx_plus[POS_BITS-1:0];
                     ptr_in   = idx_plus;
                     up_in    = 1'b0;
                     state_in = S_SCAN;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               KIND_READ: begin
                  if (idx_ok) begin
                     rd_addr  = idx_ff[POS_BITS-1:0];
                     state_in = S_FETCH;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               KIND_MARK: begin
                  if (idx_ok || idx_ff == NONE_MARK) begin
                     mark_ctl.op = MK_WRITE;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               KIND_CLEAR: begin
                  count_in    = '0;
                  mark_ctl.op = MK_CLEAR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_NEIGH_A: begin
            // check the earlier neighbor, fetch the later one
            prev_lt_in = (idx_ff != '0) && (time_ff < rd_time);
            rd_addr    = idx_plus[POS_BITS-1:0];
            state_in   = S_NEIGH_B;
         end

         S_NEIGH_B: begin
            // pick the direction of the move, or keep the slot
            if (prev_lt_ff) begin
               rd_addr  = idx_minus[POS_BITS-1:0];
               ptr_in   = idx_minus;
               up_in    = 1'b1;
               state_in = S_SCAN;
            end else if (next_gt) begin
               rd_addr  = idx_plus[POS_BITS-1:0];
               ptr_in   = idx_plus;
               up_in    = 1'b0;
               state_in = S_SCAN;
            end else begin
               place_in = idx_ff;
               up_in    = 1'b0;
               state_in = S_PLACE;
            end
         end

         S_SCAN: begin
            if (up_ff) begin
               // shift later points up by one slot; a moved point goes before equal times
               if ((rd_time > time_ff) || (kind_ff == KIND_SET && rd_time == time_ff)) begin
                  wr_en   = 1'b1;
                  wr_addr = ptr_plus[POS_BITS-1:0];
                  if (ptr_ff == '0) begin
                     place_in = '0;
                     state_in = S_PLACE;
                  end else begin
                     ptr_in  = ptr_minus;
                     rd_addr = ptr_minus[POS_BITS-1:0];
                  end
               end else begin
                  place_in = ptr_plus;
                  state_in = S_PLACE;
               end
            end else begin
               // shift points down by one slot
               if (down_go) begin
                  wr_en   = 1'b1;
                  wr_addr = ptr_minus[POS_BITS-1:0];
                  ptr_in  = ptr_plus;
                  rd_addr = ptr_plus[POS_BITS-1:0];
               end else begin
                  place_in = ptr_minus;
                  state_in = S_PLACE;
               end
            end
         end

         S_PLACE: begin
            // store the point for set and insert, and update count and markers
            state_in = S_DONE;
            wr_data  = {time_ff, value_ff};
            case (kind_ff)
               KIND_SET: begin
                  wr_en        = 1'b1;
                  wr_addr      = place_ff[POS_BITS-1:0];
                  res_index_in = place_ff[POS_BITS-1:0];
                  if (up_ff) begin
                     mark_ctl.op = MK_UP;
                     mark_lo     = place_ff;
                     mark_hi     = idx_ff;
                  end else begin
                     mark_ctl.op = MK_DOWN;
                     mark_lo     = idx_ff;
                     mark_hi     = place_ff;
                  end
               end
               KIND_INSERT: begin
                  wr_en        = 1'b1;
                  wr_addr      = place_ff[POS_BITS-1:0];
                  res_index_in = place_ff[POS_BITS-1:0];
                  count_in     = count_ff + 1'b1;
                  mark_ctl.op  = MK_UP;
                  mark_lo      = place_ff;
                  mark_hi      = NONE_MARK;
               end
               KIND_DELETE: begin
                  count_in    = count_ff - 1'b1;
                  mark_ctl.op = MK_DROP;
                  mark_lo     = idx_ff;
               end
               default: begin
                  mark_ctl.op = MK_HOLD;
               end
            endcase
         end

         S_FETCH: begin
            // capture the read data
            res_time_in  = rd_time;
            res_value_in = rd_data[VALUE_BITS-1:0];
            state_in     = S_DONE;
         end

         S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_time_in   = res_time_ff;
               rsp_value_in  = res_value_ff;
               rsp_count_in  = count_ff;
               rsp_marks_in  = marks;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold command and result payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      time_ff       <= time_in;
      value_ff      <= value_in;
      sel_ff        <= sel_in;
      ptr_ff        <= ptr_in;
      place_ff      <= place_in;
      up_ff         <= up_in;
      prev_lt_ff    <= prev_lt_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_time_ff   <= res_time_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_marks_ff  <= rsp_marks_in;
   end

   // Drive the channels
   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.result_index   = rsp_index_ff;
   assign rsp_chan.read_time      = rsp_time_ff;
   assign rsp_chan.read_value     = rsp_value_ff;
   assign rsp_chan.point_count    = rsp_count_ff;
   assign rsp_chan.sus_begin_out  = rsp_marks_ff[MS_SUS_BEGIN];
   assign rsp_chan.sus_end_out    = rsp_marks_ff[MS_SUS_END];
   assign rsp_chan.loop_begin_out = rsp_marks_ff[MS_LOOP_START];
   assign rsp_chan.loop_end_out   = rsp_marks_ff[MS_LOOP_END];

endmodule

`default_nettype wire
